// ===== sv/pbin_pkg.sv =====
// ---------------------------------------------------------------------------
// pbin_pkg
// Shared types and codes for the photon image binning block.
// ---------------------------------------------------------------------------
package pbin_pkg;

  // request codes carried in in_tuser
  typedef logic [1:0] pbin_req_t;
  localparam pbin_req_t REQ_HIT   = 2'd0;
  localparam pbin_req_t REQ_READ  = 2'd1;
  localparam pbin_req_t REQ_WRITE = 2'd2;

  // operation the back end carries out for a queued item
  typedef logic [1:0] pbin_kind_t;
  localparam pbin_kind_t KIND_NONE  = 2'd0;
  localparam pbin_kind_t KIND_HIT   = 2'd1;
  localparam pbin_kind_t KIND_READ  = 2'd2;
  localparam pbin_kind_t KIND_WRITE = 2'd3;

  // configuration register indexes
  typedef logic [2:0] pbin_reg_t;
  localparam pbin_reg_t REG_X_MIN      = 3'd0;
  localparam pbin_reg_t REG_X_MAX      = 3'd1;
  localparam pbin_reg_t REG_Y_MIN      = 3'd2;
  localparam pbin_reg_t REG_Y_MAX      = 3'd3;
  localparam pbin_reg_t REG_X_INV_STEP = 3'd4;
  localparam pbin_reg_t REG_Y_INV_STEP = 3'd5;
  localparam pbin_reg_t REG_IMG_WIDTH  = 3'd6;
  localparam pbin_reg_t REG_IMG_HEIGHT = 3'd7;

  localparam logic [31:0] INV_STEP_RST = 32'd65536;
  localparam logic [8:0]  IMG_SIZE_RST = 9'd256;

  // one half in Q32.32, added before the fraction is dropped
  localparam logic [63:0] ROUND_HALF = 64'h0000_0000_8000_0000;

  localparam int QUEUE_DEPTH = 4;

  // control part of one queued item
  typedef struct packed {
    pbin_kind_t  kind;
    logic [7:0]  col;
    logic [7:0]  row;
    logic        batch;
  } pbin_tag_t;

endpackage

// ===== sv/pbin_ram.sv =====
// ---------------------------------------------------------------------------
// pbin_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module pbin_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/pbin_queue.sv =====
// ---------------------------------------------------------------------------
// pbin_queue
// Short FIFO between the classifying front end and the pixel update back end.
// ---------------------------------------------------------------------------
module pbin_queue #(
  parameter int W     = 64,
  parameter int DEPTH = 4,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         full,
  output logic         empty
);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== sv/pbin_front.sv =====
// ---------------------------------------------------------------------------
// pbin_front
// Configuration registers, box test and bin arithmetic. Three stages turn an
// accepted request into a pixel address and an operation for the back end.
// ---------------------------------------------------------------------------
module pbin_front #(
  parameter int MAX_W      = 256,
  parameter int MAX_H      = 256,
  parameter int COUNT_BITS = 32,
  localparam int AW = $clog2(MAX_W * MAX_H)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // configuration
  input  logic                     cfg_we,
  input  logic [2:0]               cfg_addr,
  input  logic [31:0]              cfg_data,
  // request stream
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [111:0]             in_tdata,
  input  logic [1:0]               in_tuser,
  input  logic                     in_tlast,
  // queue side
  input  logic                     clr_busy,
  input  logic                     q_full,
  output logic                     q_push,
  output pbin_pkg::pbin_tag_t      q_tag,
  output logic [AW-1:0]            q_addr,
  output logic [COUNT_BITS-1:0]    q_wdata
);
  import pbin_pkg::*;

  localparam logic [AW-1:0] ROW_PITCH = AW'(MAX_W);

  // configuration registers
  logic signed [31:0] x_min_r, x_max_r, y_min_r, y_max_r;
  logic [31:0]        x_inv_step_r, y_inv_step_r;
  logic [8:0]         img_width_r, img_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r      <= '0;
      x_max_r      <= '0;
      y_min_r      <= '0;
      y_max_r      <= '0;
      x_inv_step_r <= INV_STEP_RST;
      y_inv_step_r <= INV_STEP_RST;
      img_width_r  <= IMG_SIZE_RST;
      img_height_r <= IMG_SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_X_MIN:      x_min_r      <= cfg_data;
        REG_X_MAX:      x_max_r      <= cfg_data;
        REG_Y_MIN:      y_min_r      <= cfg_data;
        REG_Y_MAX:      y_max_r      <= cfg_data;
        REG_X_INV_STEP: x_inv_step_r <= cfg_data;
        REG_Y_INV_STEP: y_inv_step_r <= cfg_data;
        REG_IMG_WIDTH:  img_width_r  <= cfg_data[8:0];
        REG_IMG_HEIGHT: img_height_r <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // last column and row in use
  logic [31:0] lim_x, lim_y;

  always_comb begin
    if (img_width_r == '0) begin
      lim_x = '0;
    end else if ({23'd0, img_width_r} > 32'(MAX_W)) begin
      lim_x = 32'(MAX_W - 1);
    end else begin
      lim_x = {23'd0, img_width_r} - 32'd1;
    end
    if (img_height_r == '0) begin
      lim_y = '0;
    end else if ({23'd0, img_height_r} > 32'(MAX_H)) begin
      lim_y = 32'(MAX_H - 1);
    end else begin
      lim_y = {23'd0, img_height_r} - 32'd1;
    end
  end

  logic adv;
  logic s3_valid_r;

  // whole pipe holds while the last stage cannot push
  assign adv       = !(s3_valid_r && q_full);
  assign in_tready = adv && !clr_busy;
  assign q_push    = s3_valid_r && adv;

  // stage 1: captured request
  logic              s1_valid_r;
  pbin_req_t         s1_req_r;
  logic signed [31:0] s1_cx_r, s1_cy_r;
  logic [7:0]        s1_pc_r, s1_pr_r;
  logic [31:0]       s1_wc_r;
  logic              s1_be_r;

  // stage 2: offsets and range tests
  logic        s2_valid_r;
  pbin_req_t   s2_req_r;
  logic        s2_inbox_r, s2_acc_ok_r;
  logic [31:0] s2_off_x_r, s2_off_y_r;
  logic [7:0]  s2_pc_r, s2_pr_r;
  logic [31:0] s2_wc_r;
  logic        s2_be_r;

  // stage 3: products
  pbin_req_t   s3_req_r;
  logic        s3_inbox_r, s3_acc_ok_r;
  logic [63:0] s3_prod_x_r, s3_prod_y_r;
  logic [7:0]  s3_pc_r, s3_pr_r;
  logic [31:0] s3_wc_r;
  logic        s3_be_r;

  logic        inbox;
  logic        acc_ok;
  logic [31:0] off_x, off_y;
  logic [63:0] prod_x, prod_y;

  assign inbox = (s1_cx_r >= x_min_r) && (s1_cx_r <= x_max_r) &&
                 (s1_cy_r >= y_min_r) && (s1_cy_r <= y_max_r);
  assign acc_ok = ({24'd0, s1_pc_r} < 32'(MAX_W)) && ({24'd0, s1_pr_r} < 32'(MAX_H));
  // exact inside the box: 0 .. 2^32-1
  assign off_x  = s1_cx_r - x_min_r;
  assign off_y  = s1_cy_r - y_min_r;
  assign prod_x = s2_off_x_r * x_inv_step_r;
  assign prod_y = s2_off_y_r * y_inv_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_tvalid && in_tready;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_req_r    <= in_tuser;
      s1_cx_r     <= in_tdata[31:0];
      s1_cy_r     <= in_tdata[63:32];
      s1_pc_r     <= in_tdata[71:64];
      s1_pr_r     <= in_tdata[79:72];
      s1_wc_r     <= in_tdata[111:80];
      s1_be_r     <= in_tlast;

      s2_req_r    <= s1_req_r;
      s2_inbox_r  <= inbox;
      s2_acc_ok_r <= acc_ok;
      s2_off_x_r  <= off_x;
      s2_off_y_r  <= off_y;
      s2_pc_r     <= s1_pc_r;
      s2_pr_r     <= s1_pr_r;
      s2_wc_r     <= s1_wc_r;
      s2_be_r     <= s1_be_r;

      s3_req_r    <= s2_req_r;
      s3_inbox_r  <= s2_inbox_r;
      s3_acc_ok_r <= s2_acc_ok_r;
      s3_prod_x_r <= prod_x;
      s3_prod_y_r <= prod_y;
      s3_pc_r     <= s2_pc_r;
      s3_pr_r     <= s2_pr_r;
      s3_wc_r     <= s2_wc_r;
      s3_be_r     <= s2_be_r;
    end
  end

  // stage 3: round half up, clamp, form address and operation
  logic [63:0]   rnd_x, rnd_y;
  logic [31:0]   col_c, row_c;
  logic [AW-1:0] hit_addr, acc_addr;

  assign rnd_x    = s3_prod_x_r + ROUND_HALF;
  assign rnd_y    = s3_prod_y_r + ROUND_HALF;
  assign col_c    = (rnd_x[63:32] > lim_x) ? lim_x : rnd_x[63:32];
  assign row_c    = (rnd_y[63:32] > lim_y) ? lim_y : rnd_y[63:32];
  assign hit_addr = AW'(row_c) * ROW_PITCH + AW'(col_c);
  assign acc_addr = AW'(s3_pr_r) * ROW_PITCH + AW'(s3_pc_r);

  always_comb begin
    q_tag.kind  = KIND_NONE;
    q_tag.col   = '0;
    q_tag.row   = '0;
    q_tag.batch = s3_be_r;
    q_addr      = acc_addr;
    q_wdata     = COUNT_BITS'(s3_wc_r);
    unique case (s3_req_r)
      REQ_HIT: begin
        if (s3_inbox_r) begin
          q_tag.kind = KIND_HIT;
          q_tag.col  = col_c[7:0];
          q_tag.row  = row_c[7:0];
          q_addr     = hit_addr;
        end
      end
      REQ_READ, REQ_WRITE: begin
        if (s3_acc_ok_r) begin
          q_tag.kind = (s3_req_r == REQ_READ) ? KIND_READ : KIND_WRITE;
          q_tag.col  = s3_pc_r;
          q_tag.row  = s3_pr_r;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/pbin_back.sv =====
// ---------------------------------------------------------------------------
// pbin_back
// Pixel store with clearing pass, read-modify-write with forwarding of the
// last write, and the result output register.
// ---------------------------------------------------------------------------
module pbin_back #(
  parameter int MAX_W      = 256,
  parameter int MAX_H      = 256,
  parameter int COUNT_BITS = 32,
  localparam int DEPTH = MAX_W * MAX_H,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // queue side
  input  logic                  q_empty,
  input  pbin_pkg::pbin_tag_t   q_tag,
  input  logic [AW-1:0]         q_addr,
  input  logic [COUNT_BITS-1:0] q_wdata,
  output logic                  q_pop,
  output logic                  clr_busy,
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [47:0]           out_tdata,
  output logic [0:0]            out_tuser,
  output logic                  out_tlast
);
  import pbin_pkg::*;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  // clearing pass after reset
  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  assign clr_busy = clr_busy_r;

  // update stage and output register
  logic                  b2_valid_r;
  pbin_tag_t             b2_tag_r;
  logic [AW-1:0]         b2_addr_r;
  logic [COUNT_BITS-1:0] b2_wdata_r;

  logic                  out_valid_r;
  logic                  out_landed_r;
  logic [7:0]            out_col_r, out_row_r;
  logic [31:0]           out_count_r;
  logic                  out_batch_r;

  logic                  fwd_valid_r;
  logic [AW-1:0]         fwd_addr_r;
  logic [COUNT_BITS-1:0] fwd_data_r;

  logic                  out_take, adv;
  logic [COUNT_BITS-1:0] rd_data, cur, upd;
  logic                  upd_we, landed;

  assign out_take = !out_valid_r || out_tready;
  assign adv      = !b2_valid_r || out_take;
  assign q_pop    = adv && !q_empty && !clr_busy_r;

  pbin_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (clr_busy_r || (b2_valid_r && out_take && upd_we)),
    .waddr (clr_busy_r ? clr_addr_r : b2_addr_r),
    .wdata (clr_busy_r ? '0 : upd),
    .re    (q_pop),
    .raddr (q_addr),
    .rdata (rd_data)
  );

  // the item ahead may have written this pixel in the cycle of our read
  assign cur = (fwd_valid_r && fwd_addr_r == b2_addr_r) ? fwd_data_r : rd_data;

  always_comb begin
    upd    = cur;
    upd_we = 1'b0;
    landed = 1'b1;
    unique case (b2_tag_r.kind)
      KIND_HIT: begin
        upd    = (cur == CNT_MAX) ? cur : cur + 1'b1;
        upd_we = 1'b1;
      end
      KIND_WRITE: begin
        upd    = b2_wdata_r;
        upd_we = 1'b1;
      end
      KIND_READ: ;
      KIND_NONE: begin
        upd    = '0;
        landed = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        b2_valid_r <= q_pop;
      end
      if (out_take) begin
        out_valid_r <= b2_valid_r;
      end
      if (b2_valid_r && out_take && upd_we) begin
        fwd_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b2_tag_r   <= q_tag;
      b2_addr_r  <= q_addr;
      b2_wdata_r <= q_wdata;
    end
    if (b2_valid_r && out_take) begin
      out_landed_r <= landed;
      out_col_r    <= b2_tag_r.col;
      out_row_r    <= b2_tag_r.row;
      out_count_r  <= 32'(upd);
      out_batch_r  <= b2_tag_r.batch;
      if (upd_we) begin
        fwd_addr_r <= b2_addr_r;
        fwd_data_r <= upd;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_count_r, out_row_r, out_col_r};
  assign out_tuser  = out_landed_r;
  assign out_tlast  = out_batch_r;

endmodule

// ===== sv/photon_image_binning_core.sv =====
// ---------------------------------------------------------------------------
// photon_image_binning_core
// 2D histogram of photon hits with pixel read and write access.
//
//   port group  dir  tdata (low bit up)                        tuser / tlast
//   in_*        in   coord_x, coord_y, pixel_col, pixel_row,   req_type /
//                    write_count                               batch_end
//   out_*       out  col_out, row_out, count_out               landed /
//                                                              batch_done
//   cfg_*       in   cfg_addr = register index, cfg_data       -
//
// One item per cycle sustained while out_tready is high; one result per input
// transfer (three front stages, queue, store read, output register).
// Same-pixel updates in consecutive cycles go through the write forwarding
// path, so the store's single read and write port sets the rate.
// After reset a clearing pass zeroes the store with in_tready low. A stalled
// output fills the queue and then holds in_tready low; the input side never
// stalls the output.
// ---------------------------------------------------------------------------
module photon_image_binning_core #(
  parameter int MAX_W      = 256,
  parameter int MAX_H      = 256,
  parameter int COUNT_BITS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [111:0] in_tdata,   // coord_x, coord_y, pixel_col, pixel_row, write_count
  input  logic [1:0]   in_tuser,   // req_type
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [47:0]  out_tdata,  // col_out, row_out, count_out
  output logic [0:0]   out_tuser,  // landed
  output logic         out_tlast
);
  import pbin_pkg::*;

  localparam int AW    = $clog2(MAX_W * MAX_H);
  localparam int TAG_W = $bits(pbin_tag_t);
  localparam int QW    = TAG_W + AW + COUNT_BITS;

  logic                  clr_busy, q_full, q_empty, q_push, q_pop;
  pbin_tag_t             f_tag;
  logic [AW-1:0]         f_addr;
  logic [COUNT_BITS-1:0] f_wdata;
  logic [QW-1:0]         q_dout;
  pbin_tag_t             b_tag;

  pbin_front #(
    .MAX_W      (MAX_W),
    .MAX_H      (MAX_H),
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .clr_busy  (clr_busy),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_tag     (f_tag),
    .q_addr    (f_addr),
    .q_wdata   (f_wdata)
  );

  pbin_queue #(
    .W     (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   ({f_tag, f_addr, f_wdata}),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  assign b_tag = pbin_tag_t'(q_dout[QW-1 -: TAG_W]);

  pbin_back #(
    .MAX_W      (MAX_W),
    .MAX_H      (MAX_H),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_tag      (b_tag),
    .q_addr     (q_dout[COUNT_BITS +: AW]),
    .q_wdata    (q_dout[COUNT_BITS-1:0]),
    .q_pop      (q_pop),
    .clr_busy   (clr_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== sv/pbin_checker.sv =====
// ---------------------------------------------------------------------------
// pbin_checker
// Port-level checks for the photon image binning core, bound to the top.
// ---------------------------------------------------------------------------
module pbin_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [47:0]  out_tdata,
  input logic [0:0]   out_tuser,
  input logic         out_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // the store is being cleared right after reset
  a_clear_blocks_input: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input accepted during clearing pass");

  a_no_result_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown right after reset");

  // a miss or ignored request reports no pixel and no count
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 48'd0)
    else $error("miss result carries pixel data");

endmodule

bind photon_image_binning_core pbin_checker u_pbin_checker (.*);
